/* hw/rtl/bc_pkg.sv */
// ----------------------------------------------------------------------------
// Barometer compensation package
// Shared transaction types, configuration layout and arithmetic constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bc_pkg;

   typedef struct packed {
      logic [15:0] raw_temp;
      logic [18:0] raw_press;
   } bc_req_type;

   typedef struct packed {
      logic signed [15:0] temperature;
      logic [19:0]        pressure;
      logic               div_error;
   } bc_rsp_type;

   typedef struct packed {
      logic [31:0] ac1_ac2;
      logic [31:0] ac3_ac4;
      logic [31:0] ac5_ac6;
      logic [31:0] b1_b2;
      logic [31:0] mc_md;
      logic [1:0]  oss;
   } bc_cfg_type;

   // queue entry: front-end result for one transaction
   typedef struct packed {
      logic signed [17:0] x1;
      logic signed [18:0] dsor;
      logic [18:0]        raw_press;
   } bc_ent_type;

   // sideband through the temperature divider
   typedef struct packed {
      logic signed [17:0] x1;
      logic [18:0]        raw_press;
      logic               err;
      logic               qneg;
   } bc_s1_type;

   // sideband through the pressure divider
   typedef struct packed {
      logic signed [15:0] temp;
      logic               err;
      logic               big;
      logic               neg;
   } bc_s2_type;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_AC12 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AC34 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AC56 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_B12  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MCMD = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OSS  = 3'd5;

   localparam logic [1:0] OSS_RESET = 2'd3;

   // divider geometry
   localparam int DIV1_NW = 27;
   localparam int DIV1_DW = 18;
   localparam int DIV2_NW = 62;
   localparam int DIV2_DW = 42;

   localparam logic signed [27:0] T_OFFSET  = 28'sd4000;
   localparam logic [15:0]        P_SCALE   = 16'd50000;
   localparam logic signed [63:0] B7_LIMIT  = 64'sh80000000;
   localparam logic [11:0]        C_SQ      = 12'd3038;
   localparam logic [12:0]        C_LIN     = 13'd7357;
   localparam logic signed [29:0] C_OFF     = 30'sd3791;
   localparam logic [19:0]        P_MAX     = 20'hFFFFF;
   // floor((a+2)/4) + 32768 folded into one add
   localparam logic signed [43:0] Y_BIAS    = 44'sd131074;

endpackage

`default_nettype wire

/* hw/rtl/bc_div.sv */
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage, sideband carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module bc_div #(
   parameter int NW = 27,
   parameter int DW = 18,
   parameter int SW = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_vld,
   input  wire logic [NW-1:0] in_num,
   input  wire logic [DW-1:0] in_den,
   input  wire logic [SW-1:0] in_side,
   output logic               out_vld,
   output logic [NW-1:0]      out_quo,
   output logic [SW-1:0]      out_side
);

   logic          vld_ff  [NW];
   logic [DW-1:0] rem_ff  [NW];
   logic [NW-1:0] work_ff [NW];
   logic [DW-1:0] den_ff  [NW];
   logic [SW-1:0] side_ff [NW];

   for (genvar i = 0; i < NW; i++) begin : g_stage
      logic          vld_s;
      logic [DW-1:0] rem_s;
      logic [NW-1:0] work_s;
      logic [DW-1:0] den_s;
      logic [SW-1:0] side_s;
      logic [DW:0]   trial;
      logic          ge;

      if (i == 0) begin : g_first
         assign vld_s  = in_vld;
         assign rem_s  = '0;
         assign work_s = in_num;
         assign den_s  = in_den;
         assign side_s = in_side;
      end else begin : g_next
         assign vld_s  = vld_ff[i-1];
         assign rem_s  = rem_ff[i-1];
         assign work_s = work_ff[i-1];
         assign den_s  = den_ff[i-1];
         assign side_s = side_ff[i-1];
      end

      assign trial = {rem_s, work_s[NW-1]};
      assign ge    = trial >= {1'b0, den_s};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_s;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i]  <= ge ? DW'(trial - {1'b0, den_s}) : trial[DW-1:0];
         work_ff[i] <= {work_s[NW-2:0], ge};
         den_ff[i]  <= den_s;
         side_ff[i] <= side_s;
      end
   end

   assign out_vld  = vld_ff[NW-1];
   assign out_quo  = work_ff[NW-1];
   assign out_side = side_ff[NW-1];

endmodule

`default_nettype wire

/* hw/rtl/bc_front.sv */
// ----------------------------------------------------------------------------
// Barometer compensation front end
// Takes transactions, forms x1 and the temperature divisor, pushes the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bc_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire bc_pkg::bc_req_type req_data,
   input  wire bc_pkg::bc_cfg_type cfg,
   input  wire logic              q_full,
   output logic                   push,
   output bc_pkg::bc_ent_type     push_data
);

   logic                f0_vld_ff;
   logic                f1_vld_ff;
   bc_pkg::bc_req_type  f0_req_ff;
   logic signed [33:0]  f1_prod_ff;
   logic [18:0]         f1_press_ff;

   logic                stall;
   logic signed [16:0]  diff;
   logic signed [16:0]  ac5;
   logic signed [15:0]  md;
   logic signed [17:0]  x1;

   assign stall = f1_vld_ff & q_full;
   assign busy  = stall;

   assign diff = $signed({1'b0, f0_req_ff.raw_temp}) - $signed({1'b0, cfg.ac5_ac6[15:0]});
   assign ac5  = $signed({1'b0, cfg.ac5_ac6[31:16]});
   assign md   = cfg.mc_md[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_vld_ff <= 1'b0;
         f1_vld_ff <= 1'b0;
      end else if (!stall) begin
         f0_vld_ff <= start;
         f1_vld_ff <= f0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         f0_req_ff   <= req_data;
         f1_prod_ff  <= diff * ac5;
         f1_press_ff <= f0_req_ff.raw_press;
      end
   end

   // floor shift by 15; range fits 18 bits
   assign x1 = f1_prod_ff[32:15];

   assign push                = f1_vld_ff & ~q_full;
   assign push_data.x1        = x1;
   assign push_data.dsor      = $signed({x1[17], x1}) + $signed({{3{md[15]}}, md});
   assign push_data.raw_press = f1_press_ff;

endmodule

`default_nettype wire

/* hw/rtl/bc_queue.sv */
// ----------------------------------------------------------------------------
// Barometer compensation queue
// Small FIFO between front and back; head is drained every cycle it is valid.
// ----------------------------------------------------------------------------
`default_nettype none

module bc_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire bc_pkg::bc_ent_type push_data,
   output logic                    full,
   output logic                    pop_vld,
   output bc_pkg::bc_ent_type      pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   bc_pkg::bc_ent_type mem [DEPTH];
   logic [PW-1:0]      wr_ptr_ff;
   logic [PW-1:0]      rd_ptr_ff;
   logic [CW-1:0]      cnt_ff;
   logic [CW-1:0]      cnt_in;
   logic               pop_vld_ff;
   bc_pkg::bc_ent_type pop_data_ff;
   logic               rd;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
   endfunction

   assign rd   = cnt_ff != '0;
   assign full = cnt_ff == CW'(DEPTH);

   always_comb begin
      case ({push, rd})
         2'b10:   cnt_in = CW'(cnt_ff + 1'b1);
         2'b01:   cnt_in = CW'(cnt_ff - 1'b1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         cnt_ff     <= '0;
         pop_vld_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (rd) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         cnt_ff     <= cnt_in;
         pop_vld_ff <= rd;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
      if (rd) begin
         pop_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign pop_vld  = pop_vld_ff;
   assign pop_data = pop_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/bc_back.sv */
// ----------------------------------------------------------------------------
// Barometer compensation back end
// Temperature divide, pressure polynomial, pressure divide, second-order fix.
// ----------------------------------------------------------------------------
`default_nettype none

module bc_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bc_pkg::bc_cfg_type cfg,
   input  wire logic               in_vld,
   input  wire bc_pkg::bc_ent_type in_ent,
   output logic                    rsp_valid,
   output bc_pkg::bc_rsp_type      rsp_data
);

   localparam int S1W = $bits(bc_pkg::bc_s1_type);
   localparam int S2W = $bits(bc_pkg::bc_s2_type);

   logic signed [15:0] ac1, ac2, ac3, b1, b2, mc;
   logic [15:0]        ac4;
   logic [1:0]         oss;

   assign ac1 = cfg.ac1_ac2[31:16];
   assign ac2 = cfg.ac1_ac2[15:0];
   assign ac3 = cfg.ac3_ac4[31:16];
   assign ac4 = cfg.ac3_ac4[15:0];
   assign b1  = cfg.b1_b2[31:16];
   assign b2  = cfg.b1_b2[15:0];
   assign mc  = cfg.mc_md[31:16];
   assign oss = cfg.oss;

   logic [12:1] v_ff;

   // ---------------- temperature divider ----------------
   logic signed [26:0]          mc_sh;
   logic [bc_pkg::DIV1_NW-1:0]  n1;
   logic [18:0]                 d1abs;
   bc_pkg::bc_s1_type           s1_in, s1o;
   logic                        d1_vld;
   logic [bc_pkg::DIV1_NW-1:0]  q1;
   logic [S1W-1:0]              s1o_bits;

   assign mc_sh = {mc, 11'd0};
   assign n1    = mc[15] ? bc_pkg::DIV1_NW'(-mc_sh) : mc_sh;
   assign d1abs = in_ent.dsor[18] ? 19'(-in_ent.dsor) : in_ent.dsor;

   assign s1_in.x1        = in_ent.x1;
   assign s1_in.raw_press = in_ent.raw_press;
   assign s1_in.err       = in_ent.dsor == '0;
   assign s1_in.qneg      = mc[15] ^ in_ent.dsor[18];

   bc_div #(.NW(bc_pkg::DIV1_NW), .DW(bc_pkg::DIV1_DW), .SW(S1W)) u_div_t (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (in_vld),
      .in_num   (n1),
      .in_den   (d1abs[bc_pkg::DIV1_DW-1:0]),
      .in_side  (s1_in),
      .out_vld  (d1_vld),
      .out_quo  (q1),
      .out_side (s1o_bits)
   );
   assign s1o = s1o_bits;

   // ---------------- stage 1: b5, b6 ----------------
   logic signed [27:0] x2_1, b5_in, b6_in;
   logic signed [27:0] b5_ff, b6_ff;
   logic [18:0]        up1_ff;
   logic               err1_ff;

   assign x2_1  = s1o.qneg ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
   assign b5_in = s1o.x1 + x2_1;
   assign b6_in = b5_in - bc_pkg::T_OFFSET;

   always_ff @(posedge clock) begin
      b5_ff   <= b5_in;
      b6_ff   <= b6_in;
      up1_ff  <= s1o.raw_press;
      err1_ff <= s1o.err;
   end

   // ---------------- stage 2: squares, temperature ----------------
   logic signed [55:0] sqf;
   logic signed [43:0] pa2, pa3;
   logic signed [28:0] tsum;
   logic signed [24:0] tt;
   logic signed [15:0] tsat;
   logic [52:0]        sqf_ff;
   logic signed [43:0] pa2_ff, pa3_ff;
   logic signed [15:0] t2_ff;
   logic [18:0]        up2_ff;
   logic               err2_ff;

   assign sqf  = b6_ff * b6_ff;
   assign pa2  = ac2 * b6_ff;
   assign pa3  = ac3 * b6_ff;
   assign tsum = b5_ff + 29'sd8;
   assign tt   = tsum[28:4];

   always_comb begin
      if (tt > 25'sd32767) begin
         tsat = 16'sh7FFF;
      end else if (tt < -25'sd32768) begin
         tsat = 16'sh8000;
      end else begin
         tsat = tt[15:0];
      end
   end

   always_ff @(posedge clock) begin
      sqf_ff  <= sqf[52:0];
      pa2_ff  <= pa2;
      pa3_ff  <= pa3;
      t2_ff   <= tsat;
      up2_ff  <= up1_ff;
      err2_ff <= err1_ff;
   end

   // ---------------- stage 3: b1, b2 partial products ----------------
   logic [40:0]        sq;
   logic signed [33:0] p2h, p1h;
   logic signed [40:0] p2l, p1l;
   logic signed [33:0] p2h_ff, p1h_ff;
   logic signed [40:0] p2l_ff, p1l_ff;
   logic signed [32:0] x2a3_ff;
   logic signed [30:0] x1b3_ff;
   logic signed [15:0] t3_ff;
   logic [18:0]        up3_ff;
   logic               err3_ff;

   assign sq  = sqf_ff[52:12];
   assign p2h = b2 * $signed({1'b0, sq[40:24]});
   assign p2l = b2 * $signed({1'b0, sq[23:0]});
   assign p1h = b1 * $signed({1'b0, sq[40:24]});
   assign p1l = b1 * $signed({1'b0, sq[23:0]});

   always_ff @(posedge clock) begin
      p2h_ff  <= p2h;
      p2l_ff  <= p2l;
      p1h_ff  <= p1h;
      p1l_ff  <= p1l;
      x2a3_ff <= pa2_ff[43:11];
      x1b3_ff <= pa3_ff[43:13];
      t3_ff   <= t2_ff;
      up3_ff  <= up2_ff;
      err3_ff <= err2_ff;
   end

   // ---------------- stage 4: recombine ----------------
   logic signed [57:0] f2, f1;
   logic signed [46:0] x1a4_ff;
   logic signed [41:0] x2b4_ff;
   logic signed [32:0] x2a4_ff;
   logic signed [30:0] x1b4_ff;
   logic signed [15:0] t4_ff;
   logic [18:0]        up4_ff;
   logic               err4_ff;

   assign f2 = $signed({p2h_ff, 24'd0}) + p2l_ff;
   assign f1 = $signed({p1h_ff, 24'd0}) + p1l_ff;

   always_ff @(posedge clock) begin
      x1a4_ff <= f2[57:11];
      x2b4_ff <= f1[57:16];
      x2a4_ff <= x2a3_ff;
      x1b4_ff <= x1b3_ff;
      t4_ff   <= t3_ff;
      up4_ff  <= up3_ff;
      err4_ff <= err3_ff;
   end

   // ---------------- stage 5: b3 numerator, b4 operand ----------------
   logic signed [48:0] v5;
   logic signed [43:0] ys;
   logic signed [48:0] v5_ff;
   logic signed [41:0] y5_ff;
   logic signed [15:0] t5_ff;
   logic [18:0]        up5_ff;
   logic               err5_ff;

   assign v5 = x1a4_ff + x2a4_ff + $signed({ac1, 2'b00});
   assign ys = x1b4_ff + x2b4_ff + bc_pkg::Y_BIAS;

   always_ff @(posedge clock) begin
      v5_ff   <= v5;
      y5_ff   <= ys[43:2];
      t5_ff   <= t4_ff;
      up5_ff  <= up4_ff;
      err5_ff <= err4_ff;
   end

   // ---------------- stage 6: b3, b4 partial products ----------------
   logic signed [51:0] sh6;
   logic signed [52:0] w6;
   logic               lt6;
   logic signed [17:0] yh;
   logic [39:0]        ql6;
   logic signed [34:0] qh6;
   logic signed [50:0] b3_ff;
   logic [39:0]        ql_ff;
   logic signed [34:0] qh_ff;
   logic signed [15:0] t6_ff;
   logic [18:0]        up6_ff;
   logic               err6_ff;

   assign sh6 = v5_ff <<< oss;
   // quotient rounds toward zero: bias by 3 more when the numerator is negative
   assign lt6 = sh6 < -52'sd2;
   assign w6  = sh6 + (lt6 ? 53'sd5 : 53'sd2);
   assign yh  = y5_ff[41:24];
   assign ql6 = ac4 * y5_ff[23:0];
   assign qh6 = $signed({1'b0, ac4}) * yh;

   always_ff @(posedge clock) begin
      b3_ff   <= w6[52:2];
      ql_ff   <= ql6;
      qh_ff   <= qh6;
      t6_ff   <= t5_ff;
      up6_ff  <= up5_ff;
      err6_ff <= err5_ff;
   end

   // ---------------- stage 7: b4, up - b3 ----------------
   logic signed [58:0] g7;
   logic signed [43:0] b4;
   logic signed [51:0] e7;
   logic signed [43:0] b4_7_ff;
   logic signed [51:0] e_ff;
   logic signed [15:0] t7_ff;
   logic               err7_ff;

   assign g7 = $signed({qh_ff, 24'd0}) + $signed({19'd0, ql_ff});
   assign b4 = g7[58:15];
   assign e7 = $signed({33'd0, up6_ff}) - b3_ff;

   always_ff @(posedge clock) begin
      b4_7_ff <= b4;
      e_ff    <= e7;
      t7_ff   <= t6_ff;
      err7_ff <= err6_ff | b4[43] | (b4 == '0);
   end

   // ---------------- stage 8: b7 partial products ----------------
   logic [15:0]        k8;
   logic [39:0]        kl8;
   logic signed [44:0] kh8;
   logic [39:0]        kl_ff;
   logic signed [44:0] kh_ff;
   logic signed [43:0] b4_8_ff;
   logic signed [15:0] t8_ff;
   logic               err8_ff;

   assign k8  = bc_pkg::P_SCALE >> oss;
   assign kl8 = k8 * e_ff[23:0];
   assign kh8 = $signed({1'b0, k8}) * $signed(e_ff[51:24]);

   always_ff @(posedge clock) begin
      kl_ff   <= kl8;
      kh_ff   <= kh8;
      b4_8_ff <= b4_7_ff;
      t8_ff   <= t7_ff;
      err8_ff <= err7_ff;
   end

   // ---------------- stage 9: b7 ----------------
   logic signed [68:0] b7w;
   logic signed [63:0] b7_ff;
   logic signed [43:0] b4_9_ff;
   logic signed [15:0] t9_ff;
   logic               err9_ff;

   assign b7w = $signed({kh_ff, 24'd0}) + $signed({29'd0, kl_ff});

   always_ff @(posedge clock) begin
      b7_ff   <= b7w[63:0];
      b4_9_ff <= b4_8_ff;
      t9_ff   <= t8_ff;
      err9_ff <= err8_ff;
   end

   // ---------------- pressure divider ----------------
   logic                        big;
   logic signed [63:0]          nn;
   logic [63:0]                 nabs;
   bc_pkg::bc_s2_type           s2_in, s2o;
   logic                        d2_vld;
   logic [bc_pkg::DIV2_NW-1:0]  q2;
   logic [S2W-1:0]              s2o_bits;

   // large b7 is divided first and doubled after
   assign big  = b7_ff >= bc_pkg::B7_LIMIT;
   assign nn   = big ? b7_ff : (b7_ff <<< 1);
   assign nabs = nn[63] ? 64'(-nn) : nn;

   assign s2_in.temp = t9_ff;
   assign s2_in.err  = err9_ff;
   assign s2_in.big  = big;
   assign s2_in.neg  = nn[63];

   bc_div #(.NW(bc_pkg::DIV2_NW), .DW(bc_pkg::DIV2_DW), .SW(S2W)) u_div_p (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (v_ff[9]),
      .in_num   (nabs[bc_pkg::DIV2_NW-1:0]),
      .in_den   (b4_9_ff[bc_pkg::DIV2_DW-1:0]),
      .in_side  (s2_in),
      .out_vld  (d2_vld),
      .out_quo  (q2),
      .out_side (s2o_bits)
   );
   assign s2o = s2o_bits;

   // ---------------- stage 10: classify p, first products ----------------
   logic [62:0]        pm;
   logic               pneg10, psat10;
   logic [23:0]        pv10;
   logic [23:0]        pv_ff, pv11_ff;
   logic [31:0]        m1_ff;
   logic [36:0]        m2_ff, m2_11_ff;
   logic               pneg_ff, psat_ff, pneg11_ff, psat11_ff;
   logic signed [15:0] t10_ff, t11_ff;
   logic               err10_ff, err11_ff;

   assign pm     = s2o.big ? {q2, 1'b0} : {1'b0, q2};
   assign pneg10 = s2o.neg & (q2 != '0);
   assign psat10 = ~pneg10 & (pm[62:24] != '0);
   assign pv10   = pm[23:0];

   always_ff @(posedge clock) begin
      pv_ff    <= pv10;
      m1_ff    <= pv10[23:8] * pv10[23:8];
      m2_ff    <= pv10 * bc_pkg::C_LIN;
      pneg_ff  <= pneg10;
      psat_ff  <= psat10;
      t10_ff   <= s2o.temp;
      err10_ff <= s2o.err;
   end

   // ---------------- stage 11: square term ----------------
   logic [43:0] m3_ff;

   always_ff @(posedge clock) begin
      m3_ff     <= m1_ff * bc_pkg::C_SQ;
      m2_11_ff  <= m2_ff;
      pv11_ff   <= pv_ff;
      pneg11_ff <= pneg_ff;
      psat11_ff <= psat_ff;
      t11_ff    <= t10_ff;
      err11_ff  <= err10_ff;
   end

   // ---------------- stage 12: correction and output ----------------
   logic signed [37:0] lin;
   logic signed [21:0] x2f;
   logic signed [29:0] s12;
   logic signed [26:0] pr;
   logic [19:0]        pclamp;
   bc_pkg::bc_rsp_type rsp_in;
   bc_pkg::bc_rsp_type rsp_ff;

   assign lin = -$signed({1'b0, m2_11_ff});
   assign x2f = lin[37:16];
   assign s12 = $signed({2'b00, m3_ff[43:16]}) + x2f + bc_pkg::C_OFF;
   assign pr  = $signed({3'b000, pv11_ff}) + $signed(s12[29:4]);

   always_comb begin
      if (pneg11_ff || pr[26]) begin
         pclamp = '0;
      end else if (psat11_ff || (pr > $signed({7'd0, bc_pkg::P_MAX}))) begin
         pclamp = bc_pkg::P_MAX;
      end else begin
         pclamp = pr[19:0];
      end
   end

   always_comb begin
      if (err11_ff) begin
         rsp_in.temperature = '0;
         rsp_in.pressure    = '0;
         rsp_in.div_error   = 1'b1;
      end else begin
         rsp_in.temperature = t11_ff;
         rsp_in.pressure    = pclamp;
         rsp_in.div_error   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[11:10], d2_vld, v_ff[8:1], d1_vld};
      end
   end

   assign rsp_valid = v_ff[12];
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* hw/rtl/barometer_compensation.sv */
// ----------------------------------------------------------------------------
// Barometer compensation
// Integer temperature and pressure compensation with second-order correction.
// ----------------------------------------------------------------------------
// Raw samples enter on req_data when start is high and busy low; one sample
// may be taken every cycle. Each transaction yields exactly one result on
// rsp_data, flagged by a one-cycle rsp_valid strobe, in order. Each result
// passes the two bit-serial pipelined dividers (27 and 62 stages) and the
// multiply stages around them. Throughput is one transaction per clock
// while busy is low. The receiver has no back-pressure; the back end never
// stalls, so busy only rises if the front-end queue fills, which does not
// happen in service. The user must write calibration through the csr_
// channel (always ready) only while no transaction is in flight; the block
// itself does not enforce this. Index 0..4 hold coefficient pairs, index 5
// the oversampling setting; other indexes are ignored.
// Synchronous reset clears all pipeline valids and the queue and sets the
// coefficients to zero and the oversampling setting to 3.
// A zero temperature divisor or non-positive pressure divisor gives zero
// outputs with div_error set.
// ----------------------------------------------------------------------------
`default_nettype none

module barometer_compensation #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire bc_pkg::bc_req_type                req_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [bc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [31:0]                       csr_data,
   output logic                                   rsp_valid,
   output bc_pkg::bc_rsp_type                     rsp_data
);

   bc_pkg::bc_cfg_type cfg_ff;
   logic               csr_wr;

   logic               q_full;
   logic               push;
   bc_pkg::bc_ent_type push_data;
   logic               pop_vld;
   bc_pkg::bc_ent_type pop_data;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ac1_ac2 <= '0;
         cfg_ff.ac3_ac4 <= '0;
         cfg_ff.ac5_ac6 <= '0;
         cfg_ff.b1_b2   <= '0;
         cfg_ff.mc_md   <= '0;
         cfg_ff.oss     <= bc_pkg::OSS_RESET;
      end else if (csr_wr) begin
         case (csr_index)
            bc_pkg::CSR_AC12: cfg_ff.ac1_ac2 <= csr_data;
            bc_pkg::CSR_AC34: cfg_ff.ac3_ac4 <= csr_data;
            bc_pkg::CSR_AC56: cfg_ff.ac5_ac6 <= csr_data;
            bc_pkg::CSR_B12:  cfg_ff.b1_b2   <= csr_data;
            bc_pkg::CSR_MCMD: cfg_ff.mc_md   <= csr_data;
            bc_pkg::CSR_OSS:  cfg_ff.oss     <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   bc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   bc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop_vld   (pop_vld),
      .pop_data  (pop_data)
   );

   bc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_vld    (pop_vld),
      .in_ent    (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // error results carry zero data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.div_error |-> rsp_data.temperature == '0 && rsp_data.pressure == '0)
      else $error("error result with non-zero data");

   // nothing emerges straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe after reset");

   // oversampling write lands
   a_oss_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr && csr_index == bc_pkg::CSR_OSS |=> cfg_ff.oss == $past(csr_data[1:0]))
      else $error("oversampling write lost");

   // the front end stalls only when the queue is full
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      busy |-> q_full)
      else $error("front end stalled without a full queue");

endmodule

`default_nettype wire

/* dv/tb_barometer_compensation.sv */
// ----------------------------------------------------------------------------
// Barometer compensation testbench
// Drives raw temperature/pressure pairs through the compensation block under
// several calibration sets, predicts each result with an integer model of the
// compensation and checks every strobed result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_barometer_compensation;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   bc_pkg::bc_req_type           req_data;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [bc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [31:0]                  csr_data;
   logic                         rsp_valid;
   bc_pkg::bc_rsp_type           rsp_data;

   barometer_compensation DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   localparam int LATENCY = 140;

   // shadow calibration
   logic [31:0] cal_ac12, cal_ac34, cal_ac56, cal_b12, cal_mcmd;
   logic [1:0]  cal_oss;

   bc_pkg::bc_req_type  sample_queue[$];
   bc_pkg::bc_rsp_type  result_queue[$];
   int                  idle_left;
   bit                  gaps_on;
   bit                  failed;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic bc_pkg::bc_rsp_type compensate(bc_pkg::bc_req_type s);
      bc_pkg::bc_rsp_type r;
      longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      longint ut, up, x1, x2, x3, b3, b4, b5, b6, b7, sq, p, t, pr;
      ac1 = longint'($signed(cal_ac12[31:16])); ac2 = longint'($signed(cal_ac12[15:0]));
      ac3 = longint'($signed(cal_ac34[31:16])); ac4 = longint'(cal_ac34[15:0]);
      ac5 = longint'(cal_ac56[31:16]);          ac6 = longint'(cal_ac56[15:0]);
      b1  = longint'($signed(cal_b12[31:16]));  b2  = longint'($signed(cal_b12[15:0]));
      mc  = longint'($signed(cal_mcmd[31:16])); md  = longint'($signed(cal_mcmd[15:0]));
      ut = longint'(s.raw_temp);
      up = longint'(s.raw_press);
      r = '0;
      r.div_error = 1'b1;
      x1 = floor_shift((ut - ac6) * ac5, 15);
      if (x1 + md == 0) return r;
      x2 = (mc * 2048) / (x1 + md);
      b5 = x1 + x2;
      t = floor_shift(b5 + 8, 4);
      b6 = b5 - 4000;
      sq = floor_shift(b6 * b6, 12);
      x1 = floor_shift(b2 * sq, 11);
      x2 = floor_shift(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = ((ac1 * 4 + x3) * (longint'(1) << cal_oss) + 2) / 4;
      x1 = floor_shift(ac3 * b6, 13);
      x2 = floor_shift(b1 * sq, 16);
      x3 = floor_shift(x1 + x2 + 2, 2);
      b4 = floor_shift(ac4 * (x3 + 32768), 15);
      if (b4 <= 0) return r;
      b7 = (up - b3) * longint'(50000 >> cal_oss);
      if (b7 < 64'sh80000000) p = (b7 * 2) / b4;
      else p = (b7 / b4) * 2;
      if (p < 0) pr = 0;
      else if (p >= 16777216) pr = 1048575;
      else begin
         x1 = (p >>> 8) * (p >>> 8);
         x1 = floor_shift(x1 * 3038, 16);
         x2 = floor_shift(-7357 * p, 16);
         pr = p + floor_shift(x1 + x2 + 3791, 4);
         if (pr < 0) pr = 0;
         if (pr > 1048575) pr = 1048575;
      end
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      r.temperature = t[15:0];
      r.pressure    = pr[19:0];
      r.div_error   = 1'b0;
      return r;
   endfunction

   // driver: one transaction per accepting edge, random idle bursts
   always @(posedge clock) begin
      if (reset) begin
         start     <= 1'b0;
         idle_left <= 0;
      end else begin
         if (start && !busy) begin
            result_queue.push_back(compensate(req_data));
            void'(sample_queue.pop_front());
         end
         if (start && busy) begin
            // hold current item
         end else if (idle_left > 0) begin
            start     <= 1'b0;
            idle_left <= idle_left - 1;
         end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            start     <= 1'b0;
            idle_left <= $urandom_range(0, 11);
         end else if (sample_queue.size() > 0) begin
            start    <= 1'b1;
            req_data <= sample_queue[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      bc_pkg::bc_rsp_type want;
      if (!reset && rsp_valid) begin
         if (result_queue.size() == 0) begin
            $display("%0t: unexpected result actual=%h", $time, rsp_data);
            failed = 1'b1;
         end else begin
            want = result_queue.pop_front();
            if (rsp_data.temperature !== want.temperature) begin
               $display("%0t: temperature expected=%0d actual=%0d", $time,
                        want.temperature, rsp_data.temperature);
               failed = 1'b1;
            end
            if (rsp_data.pressure !== want.pressure) begin
               $display("%0t: pressure expected=%0d actual=%0d", $time,
                        want.pressure, rsp_data.pressure);
               failed = 1'b1;
            end
            if (rsp_data.div_error !== want.div_error) begin
               $display("%0t: div_error expected=%0b actual=%0b", $time,
                        want.div_error, rsp_data.div_error);
               failed = 1'b1;
            end
         end
      end
   end

   task automatic write_csr(logic [bc_pkg::CSR_IDX_W-1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         bc_pkg::CSR_AC12: cal_ac12 = value;
         bc_pkg::CSR_AC34: cal_ac34 = value;
         bc_pkg::CSR_AC56: cal_ac56 = value;
         bc_pkg::CSR_B12:  cal_b12  = value;
         bc_pkg::CSR_MCMD: cal_mcmd = value;
         bc_pkg::CSR_OSS:  cal_oss  = value[1:0];
         default: ;
      endcase
   endtask

   task automatic drain;
      wait (sample_queue.size() == 0 && !start && result_queue.size() == 0);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic load_cal(logic [31:0] a12, a34, a56, bb, mm, logic [1:0] oss);
      write_csr(bc_pkg::CSR_AC12, a12);
      write_csr(bc_pkg::CSR_AC34, a34);
      write_csr(bc_pkg::CSR_AC56, a56);
      write_csr(bc_pkg::CSR_B12, bb);
      write_csr(bc_pkg::CSR_MCMD, mm);
      write_csr(bc_pkg::CSR_OSS, {30'd0, oss});
   endtask

   task automatic push_sample(logic [15:0] ut, logic [18:0] up);
      bc_pkg::bc_req_type s;
      s.raw_temp  = ut;
      s.raw_press = up;
      sample_queue.push_back(s);
   endtask

   // typical datasheet-like calibration with random wobble
   task automatic typical_cal(logic [1:0] oss);
      load_cal({16'd408 + 16'($urandom_range(0, 200)), -16'sd72},
               {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
               {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, oss);
   endtask

   initial begin
      cal_ac12 = '0; cal_ac34 = '0; cal_ac56 = '0; cal_b12 = '0; cal_mcmd = '0;
      cal_oss = bc_pkg::OSS_RESET;
      failed = 1'b0; gaps_on = 1'b1;
      reset = 1'b1; start = 1'b0; req_data = '0;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset calibration: zero temperature divisor
      push_sample(16'd27898, 19'd23843);
      push_sample(16'hFFFF, 19'h7FFFF);
      drain();

      // typical device, extremes of the fields, all oversampling settings
      for (int o = 0; o < 4; o++) begin
         typical_cal(o[1:0]);
         push_sample(16'd27898, 19'd23843 << o);
         push_sample(16'd0, 19'd0);
         push_sample(16'hFFFF, 19'h7FFFF);
         push_sample(16'd0, 19'h7FFFF);
         push_sample(16'hFFFF, 19'd0);
         drain();
      end

      // non-positive pressure divisor (ac4 zero), and a zero md divisor
      load_cal(32'h01980000, 32'h80000000, 32'hFFFFFFFF, 32'h7FFF7FFF,
               32'h8000_0000, 2'd0);
      push_sample(16'd0, 19'd1000);
      push_sample(16'hFFFF, 19'h7FFFF);
      drain();
      // extreme coefficients: saturation of temperature and pressure
      load_cal(32'h80008000, 32'h7FFFFFFF, 32'hFFFF0000, 32'h80008000,
               32'h7FFF0001, 2'd3);
      push_sample(16'hFFFF, 19'h7FFFF);
      push_sample(16'd0, 19'd0);
      push_sample(16'h8000, 19'h40000);
      drain();

      // random phases: mostly realistic calibration, some fully random
      for (int ph = 0; ph < 8; ph++) begin
         if (ph % 3 == 2)
            load_cal($urandom, $urandom, $urandom, $urandom, $urandom,
                     2'($urandom_range(0, 3)));
         else
            typical_cal(2'($urandom_range(0, 3)));
         if (ph == 7) gaps_on = 1'b0;
         for (int i = 0; i < 80; i++) begin
            if ($urandom_range(0, 3) == 0)
               push_sample(16'($urandom), 19'($urandom));
            else
               push_sample(16'($urandom_range(20000, 36000)),
                           19'($urandom_range(15000, 50000)) << cal_oss);
         end
         drain();
      end

      if (!failed)
         $display("tb_barometer_compensation OK");
      else
         $display("tb_barometer_compensation NOT OK");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_barometer_compensation NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
